>>> hw/rtl/gwcf_pkg.sv
// Package for the gear window classifier filter.
// Holds field widths, register indexes, reset values and the segment table.
// No dependencies.

package gwcf_pkg;

    localparam int GEAR_COUNT            = 6;
    localparam int SAMPLE_W              = 10;
    localparam int WINDOW_W              = 2 * SAMPLE_W;
    localparam int GEAR_W                = 3;
    localparam int SEG_W                 = 8;
    localparam int SEL_W                 = 4;
    localparam int HOLD_W                = 8;
    localparam int CFG_INDEX_W           = 3;
    localparam int CFG_DATA_W            = WINDOW_W;
    localparam int IN_TDATA_W            = 16;
    localparam int OUT_TDATA_W           = 16;
    localparam int HISTORY_DEPTH_DEFAULT = 4;
    localparam int QUEUE_DEPTH           = 2;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_GEAR1 = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_LIMIT   = 3'd6;

    localparam logic [GEAR_W-1:0] GEAR_NONE = 3'd0;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET [GEAR_COUNT] = '{
        20'd245956, 20'd336115, 20'd506235, 20'd664059, 20'd893674, 20'd971632
    };

    localparam logic [HOLD_W-1:0] HOLD_LIMIT_RESET = 8'd48;

    typedef logic [GEAR_W-1:0] gear_t;

    typedef struct packed {
        logic                   valid;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } cfg_wr_t;

    // active-low segments, bit0 = a ... bit7 = point
    function automatic logic [SEG_W-1:0] seg_pattern(input gear_t gear);
        logic [SEG_W-1:0] seg;
        unique case (gear)
            3'd1:    seg = 8'hF9;
            3'd2:    seg = 8'hA4;
            3'd3:    seg = 8'hB0;
            3'd4:    seg = 8'h99;
            3'd5:    seg = 8'h92;
            3'd6:    seg = 8'h82;
            default: seg = 8'hFF;
        endcase
        return seg;
    endfunction

endpackage

>>> hw/rtl/gwcf_front.sv
// Front end: window registers and sample classification.
// Depends on gwcf_pkg.

module gwcf_front
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  gwcf_pkg::cfg_wr_t               cfg_wr,
    input  logic [gwcf_pkg::SAMPLE_W-1:0]   sample,
    output gwcf_pkg::gear_t                 gear_class
);

    logic [gwcf_pkg::WINDOW_W-1:0] window_reg [gwcf_pkg::GEAR_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < gwcf_pkg::GEAR_COUNT; g++)
                window_reg[g] <= gwcf_pkg::WINDOW_RESET[g];
        end
        else if (cfg_wr.valid)
        begin
            for (int g = 0; g < gwcf_pkg::GEAR_COUNT; g++)
                if (cfg_wr.index == gwcf_pkg::CFG_WINDOW_GEAR1 +
                        gwcf_pkg::CFG_INDEX_W'(g))
                    window_reg[g] <= cfg_wr.data;
        end
    end

    // highest matching gear wins; bounds are exclusive
    always_comb
    begin
        gear_class = gwcf_pkg::GEAR_NONE;
        for (int g = 0; g < gwcf_pkg::GEAR_COUNT; g++)
        begin
            if (sample > window_reg[g][gwcf_pkg::SAMPLE_W-1:0] &&
                sample < window_reg[g][gwcf_pkg::WINDOW_W-1:gwcf_pkg::SAMPLE_W])
                gear_class = gwcf_pkg::GEAR_W'(g + 1);
        end
    end

endmodule

>>> hw/rtl/gwcf_queue.sv
// Short class queue between front and back.
// Depends on gwcf_pkg.

module gwcf_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  gwcf_pkg::gear_t push_data,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output gwcf_pkg::gear_t pop_data
);

    localparam int PTR_W   = $clog2(gwcf_pkg::QUEUE_DEPTH);
    localparam int COUNT_W = $clog2(gwcf_pkg::QUEUE_DEPTH + 1);

    gwcf_pkg::gear_t    entry_reg [gwcf_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [COUNT_W-1:0] count_reg;

    assign full      = (count_reg == COUNT_W'(gwcf_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(gwcf_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(gwcf_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

>>> hw/rtl/gwcf_back.sv
// Back end: class history ring, hold filter and the output register.
// Depends on gwcf_pkg.

module gwcf_back
#(
    parameter int HISTORY_DEPTH = gwcf_pkg::HISTORY_DEPTH_DEFAULT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  gwcf_pkg::cfg_wr_t                   cfg_wr,
    input  logic                                class_valid,
    input  gwcf_pkg::gear_t                     class_in,
    output logic                                class_pop,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [gwcf_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

    gwcf_pkg::gear_t                history_reg [HISTORY_DEPTH];
    logic [PTR_W-1:0]               ptr_reg, ptr_next;
    gwcf_pkg::gear_t                accepted_reg, accepted_next;
    logic [gwcf_pkg::HOLD_W-1:0]    count_reg, count_next;
    logic [gwcf_pkg::HOLD_W-1:0]    hold_limit_reg;
    logic                           out_valid_reg;
    logic [gwcf_pkg::OUT_TDATA_W-1:0] out_data_reg, out_data_next;
    gwcf_pkg::gear_t                shown;
    logic                           all_same;

    assign class_pop = class_valid && (!out_valid_reg || m_tready);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    always_comb
    begin
        // the slot being written already holds the new class
        all_same = 1'b1;
        for (int i = 0; i < HISTORY_DEPTH; i++)
            if (PTR_W'(i) != ptr_reg && history_reg[i] != class_in)
                all_same = 1'b0;

        ptr_next = (ptr_reg == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;

        accepted_next = accepted_reg;
        count_next    = count_reg;
        priority if (all_same && class_in != gwcf_pkg::GEAR_NONE)
        begin
            accepted_next = class_in;
            count_next    = '0;
            shown         = class_in;
        end
        else if (count_reg < hold_limit_reg)
        begin
            count_next = count_reg + 1'b1;
            shown      = accepted_reg;
        end
        else
        begin
            shown = gwcf_pkg::GEAR_NONE;
        end

        out_data_next = {1'b0,
                         gwcf_pkg::SEL_W'({shown, 1'b0}),
                         gwcf_pkg::seg_pattern(shown),
                         shown};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HISTORY_DEPTH; i++)
                history_reg[i] <= gwcf_pkg::GEAR_NONE;
            ptr_reg        <= '0;
            accepted_reg   <= gwcf_pkg::GEAR_NONE;
            count_reg      <= '0;
            hold_limit_reg <= gwcf_pkg::HOLD_LIMIT_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr.valid && cfg_wr.index == gwcf_pkg::CFG_HOLD_LIMIT)
                hold_limit_reg <= cfg_wr.data[gwcf_pkg::HOLD_W-1:0];
            if (class_pop)
            begin
                history_reg[ptr_reg] <= class_in;
                ptr_reg              <= ptr_next;
                accepted_reg         <= accepted_next;
                count_reg            <= count_next;
                out_valid_reg        <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (class_pop)
            out_data_reg <= out_data_next;
    end

endmodule

>>> hw/rtl/gear_window_classifier_filter_unit.sv
// Top level of the gear window classifier filter.
// Depends on gwcf_pkg, gwcf_front, gwcf_queue and gwcf_back.
//
// Usage:
//   s_* carries one sensor sample per item; m_* returns one result item per
//   input item, in order. cfg_* writes one register per handshake (index 0..5
//   gear windows, 6 hold limit, others ignored); cfg_ready is always high.
//   Configure only while no item is in flight.
// Data flow and throughput:
//   An item is classified on acceptance and written into a two-entry queue;
//   the back end pops it once the output register is free or being taken,
//   updates the history and hold state and loads the output register. The
//   result is offered from that register, and one item per cycle is sustained
//   while m_tready stays high; the back end updates the history at each pop.
// Reset:
//   Windows and hold limit return to their reset values, history holds none,
//   no gear is accepted and the queue is empty.
// Stall:
//   While m_tready is low the output register holds its item; the queue
//   absorbs two more items, then s_tready drops until the receiver moves.

module gear_window_classifier_filter_unit
#(
    parameter int HISTORY_DEPTH = gwcf_pkg::HISTORY_DEPTH_DEFAULT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [gwcf_pkg::IN_TDATA_W-1:0]     s_tdata,    // [9:0] sensor_sample
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [gwcf_pkg::OUT_TDATA_W-1:0]    m_tdata,    // [2:0] gear_shown,
                                                            // [10:3] segment_pattern,
                                                            // [14:11] select_lines
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gwcf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [gwcf_pkg::CFG_DATA_W-1:0]     cfg_data
);

    gwcf_pkg::cfg_wr_t cfg_wr;
    gwcf_pkg::gear_t   front_class;
    gwcf_pkg::gear_t   queue_class;
    logic              queue_full;
    logic              queue_not_empty;
    logic              queue_pop;
    logic              push;

    assign cfg_ready    = 1'b1;
    assign cfg_wr.valid = cfg_valid;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    assign s_tready = !queue_full;
    assign push     = s_tvalid && !queue_full;

    gwcf_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr     (cfg_wr),
        .sample     (s_tdata[gwcf_pkg::SAMPLE_W-1:0]),
        .gear_class (front_class)
    );

    gwcf_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (front_class),
        .full       (queue_full),
        .pop        (queue_pop),
        .not_empty  (queue_not_empty),
        .pop_data   (queue_class)
    );

    gwcf_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr      (cfg_wr),
        .class_valid (queue_not_empty),
        .class_in    (queue_class),
        .class_pop   (queue_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule
